>>> rtl/adaptive_timestep_controller_macros.svh
// assertion helpers shared by the rtl
`ifndef ADAPTIVE_TIMESTEP_CONTROLLER_MACROS_SVH
`define ADAPTIVE_TIMESTEP_CONTROLLER_MACROS_SVH

// same-cycle implication, quiet during reset
`define ATC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define ATC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/atc_pkg.sv
package atc_pkg;

    localparam int MAX_DIMS = 3;

    localparam logic [2:0]  MODE_RST   = 3'd3;
    localparam logic [15:0] TARGET_RST = 16'd20;
    localparam logic [15:0] CHECK_RST  = 16'd10;
    localparam logic [31:0] MIN_RST    = 32'd4295;
    localparam logic [31:0] MAX_RST    = 32'd8589935;
    localparam logic [31:0] LEN_RST    = 32'd3277;
    localparam logic [31:0] FIXED_RST  = 32'd429497;
    localparam logic [1:0]  DIMS_RST   = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_TARGET = 3'd1;
    localparam logic [2:0] REG_CHECK  = 3'd2;
    localparam logic [2:0] REG_MIN    = 3'd3;
    localparam logic [2:0] REG_MAX    = 3'd4;
    localparam logic [2:0] REG_LEN    = 3'd5;
    localparam logic [2:0] REG_FIXED  = 3'd6;
    localparam logic [2:0] REG_DIMS   = 3'd7;

    localparam logic [5:0] DIV_STEPS  = 6'd63;
    localparam logic [5:0] SQRT_STEPS = 6'd31;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQ, ST_SQ_ADD, ST_MAX, ST_F_ROOT, ST_F_WAIT, ST_F_MUL, ST_F_UPD,
        ST_FIN, ST_V_ROOT, ST_V_WAIT, ST_V_MUL, ST_V_DIV, ST_V_DWAIT, ST_L_ROOT,
        ST_L_WAIT, ST_A_HI, ST_A_LO, ST_A_ADD, ST_A_DIV, ST_A_DWAIT, ST_CAND,
        ST_B_WAIT, ST_CLAMP, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } atc_iter_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } atc_iter_sts_t;

endpackage

>>> rtl/atc_iter.sv
module atc_iter import atc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  atc_iter_req_t req,
    input  logic [63:0]   num,
    input  logic [63:0]   den,
    output atc_iter_sts_t sts,
    output logic [63:0]   result
);

    logic        run_reg;
    logic        done_reg;
    logic        is_sqrt_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] q_reg;
    logic [64:0] rem_reg;
    logic [63:0] den_reg;
    logic [31:0] root_reg;

    logic [64:0] shifted;
    logic [64:0] trial;
    logic [65:0] diff;
    logic        ge;

    // one shared subtractor: restoring divide or digit-by-digit root
    always_comb begin
        shifted = is_sqrt_reg ? {rem_reg[62:0], q_reg[63:62]} : {rem_reg[63:0], q_reg[63]};
        trial   = is_sqrt_reg ? {31'b0, root_reg, 2'b01} : {1'b0, den_reg};
        diff    = {1'b0, shifted} - {1'b0, trial};
        ge      = ~diff[65];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                run_reg <= 1'b1;
            end else if (run_reg && cnt_reg == 6'd0) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            is_sqrt_reg <= req.is_sqrt;
            cnt_reg     <= req.is_sqrt ? SQRT_STEPS : DIV_STEPS;
            q_reg       <= num;
            rem_reg     <= '0;
            den_reg     <= den;
            root_reg    <= '0;
        end else if (run_reg) begin
            cnt_reg <= cnt_reg - 6'd1;
            rem_reg <= ge ? diff[64:0] : shifted;
            if (is_sqrt_reg) begin
                q_reg    <= {q_reg[61:0], 2'b00};
                root_reg <= {root_reg[30:0], ge};
            end else begin
                q_reg <= {q_reg[62:0], ge};
            end
        end
    end

    assign sts.busy = run_reg;
    assign sts.done = done_reg;
    assign result   = is_sqrt_reg ? {32'b0, root_reg} : q_reg;

endmodule

>>> rtl/adaptive_timestep_controller.sv
// channel  | direction | beat contents
// s_       | in        | velocity, force, inverse mass, last_particle of one particle
// m_       | out       | step size and checked flag, one beat per step end
// cfg_     | in        | register index and write data, always ready
// a particle outside a check step is taken in the idle state alone, passing through the finish and
// output states when it ends the step; a check step particle runs its squares through one shared
// 32x32 multiplier, plus the force root when inverse mass is nonzero; the step end of a check
// step runs roots and divides through one shared shift-subtract unit
// synchronous active-low reset restores register defaults and schedules a check
// a step-end result waits in the output register; the next beat is taken meanwhile
`include "adaptive_timestep_controller_macros.svh"

module adaptive_timestep_controller import atc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_vel_x,
    input  logic [31:0] s_vel_y,
    input  logic [31:0] s_vel_z,
    input  logic [31:0] s_force_x,
    input  logic [31:0] s_force_y,
    input  logic [31:0] s_force_z,
    input  logic [31:0] s_inverse_mass,
    input  logic        s_last_particle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_step_size,
    output logic        m_was_checked,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // ceil(2^35 / 10) and floor(2^32 / 10)
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam logic [31:0] TWO32_DIV10 = 32'd429496729;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    // configuration
    logic [2:0]  mode_reg;
    logic [15:0] target_reg;
    logic [15:0] check_reg;
    logic [31:0] min_reg;
    logic [31:0] max_reg;
    logic [31:0] len_reg;
    logic [31:0] fixed_reg;
    logic [1:0]  dims_reg;

    // state
    state_t      state_reg, state_next;
    logic [15:0] until_reg;
    logic [31:0] cur_reg;
    logic        step_valid_reg;
    logic [63:0] max_speed_reg;
    logic [47:0] max_accel_reg;
    logic        any_massive_reg;

    // item and work registers
    logic [31:0] mag_reg [6];
    logic [31:0] im_reg;
    logic        last_reg;
    logic        en_reg;
    logic        due_reg;
    logic [2:0]  sq_idx_reg;
    logic [63:0] vsq_reg;
    logic [63:0] fsq_reg;
    logic [63:0] prod_reg;
    logic [31:0] vmax_reg;
    logic [23:0] lroot_reg;
    logic [63:0] den_reg;
    logic [63:0] dt_v_reg;
    logic [63:0] dt_a_reg;
    logic [63:0] next_reg;

    logic        m_valid_reg;
    logic [31:0] m_step_reg;
    logic        m_checked_reg;

    // shared units
    logic [31:0]   mul_a, mul_b;
    atc_iter_req_t iter_req;
    atc_iter_sts_t iter_sts;
    logic [63:0]   iter_num, iter_den, iter_res;

    logic [1:0]  dims_eff;
    logic        use_v, use_a;
    logic [31:0] eff_step;
    logic [63:0] cand;
    logic        keep_step;
    logic        cand_lt;
    logic [35:0] part9;
    logic [64:0] blend_sum;
    logic [63:0] blend_sat;
    logic [27:0] lroot10;
    logic [31:0] vin [3];
    logic [31:0] fin [3];
    logic        accept;
    logic        iter_wait;

    // blend divide by ten
    logic        blend_over;
    logic [3:0]  blend_hi;
    logic [28:0] blend_q1;
    logic [31:0] blend_rem;
    logic [5:0]  blend_small;
    logic [2:0]  blend_small_q;
    logic [31:0] blend_hi_part;
    logic [63:0] blend_q;

    atc_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (iter_req),
        .num     (iter_num),
        .den     (iter_den),
        .sts     (iter_sts),
        .result  (iter_res)
    );

    assign vin[0] = s_vel_x;
    assign vin[1] = s_vel_y;
    assign vin[2] = s_vel_z;
    assign fin[0] = s_force_x;
    assign fin[1] = s_force_y;
    assign fin[2] = s_force_z;

    always_comb begin
        if (dims_reg == 2'd0) dims_eff = 2'd1;
        else if (32'(dims_reg) > MAX_DIMS) dims_eff = 2'(MAX_DIMS);
        else dims_eff = dims_reg;
    end

    assign use_v     = mode_reg[1];
    assign use_a     = mode_reg[2];
    assign eff_step  = step_valid_reg ? cur_reg : min_reg;
    assign cand      = (dt_v_reg < dt_a_reg) ? dt_v_reg : dt_a_reg;
    assign keep_step = use_v && use_a && vmax_reg == 32'd0 && max_accel_reg == 48'd0;
    assign cand_lt   = cand < {32'b0, eff_step};
    assign part9     = {eff_step, 3'b000} + {4'b0, eff_step};
    assign blend_sum = {1'b0, cand} + {29'b0, part9};
    assign blend_sat = blend_sum[64] ? {64{1'b1}} : blend_sum[63:0];
    assign lroot10   = {1'b0, lroot_reg, 3'b000} + {3'b0, lroot_reg, 1'b0};

    // sum = hi*2^32 + lo; a quotient of 2^32 or more always clamps to max_step
    assign blend_over    = blend_sat[63:32] >= 32'd10;
    assign blend_hi      = blend_sat[35:32];
    assign blend_q1      = prod_reg[63:35];
    assign blend_rem     = blend_sat[31:0] - ({blend_q1, 3'b000} + {2'b0, blend_q1, 1'b0});
    assign blend_small   = {2'b0, blend_rem[3:0]} + {blend_hi, 2'b00} + {1'b0, blend_hi, 1'b0};
    assign blend_hi_part = 32'(blend_hi) * TWO32_DIV10;

    always_comb begin
        priority if (blend_small >= 6'd60) blend_small_q = 3'd6;
        else if (blend_small >= 6'd50) blend_small_q = 3'd5;
        else if (blend_small >= 6'd40) blend_small_q = 3'd4;
        else if (blend_small >= 6'd30) blend_small_q = 3'd3;
        else if (blend_small >= 6'd20) blend_small_q = 3'd2;
        else if (blend_small >= 6'd10) blend_small_q = 3'd1;
        else blend_small_q = 3'd0;
    end

    assign blend_q = blend_over ? 64'h1_0000_0000
                   : {32'b0, blend_hi_part} + {35'b0, blend_q1} + {61'b0, blend_small_q};

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign iter_wait = state_reg == ST_F_WAIT || state_reg == ST_V_WAIT ||
                       state_reg == ST_V_DWAIT || state_reg == ST_L_WAIT ||
                       state_reg == ST_A_DWAIT;

    // sequencer
    always_comb begin
        state_next       = state_reg;
        iter_req.start   = 1'b0;
        iter_req.is_sqrt = 1'b0;
        iter_num         = 64'd0;
        iter_den         = 64'd0;
        mul_a            = 32'd0;
        mul_b            = 32'd0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (mode_reg[0] && until_reg == 16'd0) state_next = ST_SQ;
                    else if (s_last_particle) state_next = ST_FIN;
                end
            end
            ST_SQ: begin
                mul_a = mag_reg[sq_idx_reg];
                mul_b = mag_reg[sq_idx_reg];
                if (sq_idx_reg == 3'd5) state_next = ST_SQ_ADD;
            end
            ST_SQ_ADD: state_next = ST_MAX;
            ST_MAX: state_next = (im_reg != 32'd0) ? ST_F_ROOT : ST_FIN;
            ST_F_ROOT: begin
                iter_req.start   = 1'b1;
                iter_req.is_sqrt = 1'b1;
                iter_num         = fsq_reg;
                state_next       = ST_F_WAIT;
            end
            ST_F_WAIT: if (iter_sts.done) state_next = ST_F_MUL;
            ST_F_MUL: begin
                mul_a      = iter_res[31:0];
                mul_b      = im_reg;
                state_next = ST_F_UPD;
            end
            ST_F_UPD: state_next = ST_FIN;
            ST_FIN: begin
                if (!last_reg) state_next = ST_IDLE;
                else if (en_reg && due_reg) begin
                    if (use_a && !any_massive_reg) state_next = ST_OUT;
                    else if (use_v) state_next = ST_V_ROOT;
                    else if (use_a) state_next = ST_L_ROOT;
                    else state_next = ST_CAND;
                end else state_next = ST_OUT;
            end
            ST_V_ROOT: begin
                iter_req.start   = 1'b1;
                iter_req.is_sqrt = 1'b1;
                iter_num         = max_speed_reg;
                state_next       = ST_V_WAIT;
            end
            ST_V_WAIT: if (iter_sts.done) state_next = ST_V_MUL;
            ST_V_MUL: begin
                mul_a      = vmax_reg;
                mul_b      = {16'b0, target_reg};
                state_next = ST_V_DIV;
            end
            ST_V_DIV: begin
                iter_req.start = 1'b1;
                iter_num       = {len_reg, 32'b0};
                iter_den       = prod_reg;
                state_next     = ST_V_DWAIT;
            end
            ST_V_DWAIT: if (iter_sts.done) state_next = use_a ? ST_L_ROOT : ST_CAND;
            ST_L_ROOT: begin
                iter_req.start   = 1'b1;
                iter_req.is_sqrt = 1'b1;
                iter_num         = {16'b0, len_reg, 16'b0};
                state_next       = ST_L_WAIT;
            end
            ST_L_WAIT: if (iter_sts.done) state_next = ST_A_HI;
            // 48 x 16 product split into two passes of the 32 x 32 multiplier
            ST_A_HI: begin
                mul_a      = max_accel_reg[47:16];
                mul_b      = {16'b0, target_reg};
                state_next = ST_A_LO;
            end
            ST_A_LO: begin
                mul_a      = {16'b0, max_accel_reg[15:0]};
                mul_b      = {16'b0, target_reg};
                state_next = ST_A_ADD;
            end
            ST_A_ADD: state_next = ST_A_DIV;
            ST_A_DIV: begin
                iter_req.start = 1'b1;
                iter_num       = {4'b0, lroot10, 32'b0};
                iter_den       = den_reg;
                state_next     = ST_A_DWAIT;
            end
            ST_A_DWAIT: if (iter_sts.done) state_next = ST_CAND;
            ST_CAND: begin
                if (keep_step) state_next = ST_OUT;
                else if (cand_lt) state_next = ST_CLAMP;
                else begin
                    // low word times the reciprocal of ten, used next cycle
                    mul_a      = blend_sat[31:0];
                    mul_b      = RECIP10;
                    state_next = ST_B_WAIT;
                end
            end
            ST_B_WAIT: state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_OUT;
            ST_OUT: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RST;
            target_reg <= TARGET_RST;
            check_reg  <= CHECK_RST;
            min_reg    <= MIN_RST;
            max_reg    <= MAX_RST;
            len_reg    <= LEN_RST;
            fixed_reg  <= FIXED_RST;
            dims_reg   <= DIMS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[2:0];
                REG_TARGET: target_reg <= cfg_data[15:0];
                REG_CHECK:  check_reg  <= cfg_data[15:0];
                REG_MIN:    min_reg    <= cfg_data;
                REG_MAX:    max_reg    <= cfg_data;
                REG_LEN:    len_reg    <= cfg_data;
                REG_FIXED:  fixed_reg  <= cfg_data;
                REG_DIMS:   dims_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // persistent state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            until_reg       <= 16'd0;
            cur_reg         <= 32'd0;
            step_valid_reg  <= 1'b0;
            max_speed_reg   <= 64'd0;
            max_accel_reg   <= 48'd0;
            any_massive_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_OUT) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_MAX: begin
                    if (vsq_reg > max_speed_reg) max_speed_reg <= vsq_reg;
                end
                ST_F_UPD: begin
                    if (!any_massive_reg || prod_reg[63:16] > max_accel_reg)
                        max_accel_reg <= prod_reg[63:16];
                    any_massive_reg <= 1'b1;
                end
                ST_FIN: begin
                    if (last_reg && en_reg) begin
                        if (due_reg) until_reg <= check_reg;
                        else if (until_reg != 16'd0) until_reg <= until_reg - 16'd1;
                        // acceleration bound with nothing massive falls to min_step, or max_step if that is smaller
                        if (due_reg && use_a && !any_massive_reg) begin
                            cur_reg        <= (min_reg > max_reg) ? max_reg : min_reg;
                            step_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_CLAMP: begin
                    if (next_reg > {32'b0, max_reg}) cur_reg <= max_reg;
                    else if (next_reg < {32'b0, min_reg}) cur_reg <= min_reg;
                    else cur_reg <= next_reg[31:0];
                    step_valid_reg <= 1'b1;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg     <= 1'b1;
                        max_speed_reg   <= 64'd0;
                        max_accel_reg   <= 48'd0;
                        any_massive_reg <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload and work registers
    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_step_reg    <= en_reg ? eff_step : fixed_reg;
            m_checked_reg <= en_reg && due_reg;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    for (int d = 0; d < 3; d++) begin
                        mag_reg[d]     <= (d < int'(dims_eff)) ? mag32(vin[d]) : 32'd0;
                        mag_reg[d + 3] <= (d < int'(dims_eff)) ? mag32(fin[d]) : 32'd0;
                    end
                    im_reg     <= s_inverse_mass;
                    last_reg   <= s_last_particle;
                    en_reg     <= mode_reg[0];
                    due_reg    <= mode_reg[0] && until_reg == 16'd0;
                    sq_idx_reg <= 3'd0;
                    vsq_reg    <= 64'd0;
                    fsq_reg    <= 64'd0;
                end
            end
            ST_SQ: begin
                sq_idx_reg <= sq_idx_reg + 3'd1;
                // product of the previous square lands now
                if (sq_idx_reg != 3'd0) begin
                    if (sq_idx_reg <= 3'd3) vsq_reg <= vsq_reg + prod_reg;
                    else fsq_reg <= fsq_reg + prod_reg;
                end
            end
            ST_SQ_ADD: fsq_reg <= fsq_reg + prod_reg;
            ST_FIN: begin
                dt_v_reg <= 64'h1_0000_0000;
                dt_a_reg <= 64'h1_0000_0000;
            end
            ST_V_WAIT:  if (iter_sts.done) vmax_reg <= iter_res[31:0];
            ST_V_DWAIT: if (iter_sts.done) dt_v_reg <= iter_res;
            ST_L_WAIT:  if (iter_sts.done) lroot_reg <= iter_res[23:0];
            ST_A_LO:    den_reg <= {prod_reg[47:0], 16'b0};
            ST_A_ADD:   den_reg <= den_reg + prod_reg;
            ST_A_DWAIT: if (iter_sts.done) dt_a_reg <= iter_res;
            ST_CAND:    if (cand_lt) next_reg <= cand;
            ST_B_WAIT:  next_reg <= blend_q;
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_step_size   = m_step_reg;
    assign m_was_checked = m_checked_reg;

    `ATC_ASSERT_SAME(a_iter_done_waited, iter_sts.done, iter_wait, "shared unit finished outside a wait state")
    `ATC_ASSERT_SAME(a_iter_idle_start, iter_req.start, !iter_sts.busy, "shared unit restarted while busy")
    `ATC_ASSERT_NEXT(a_step_valid_sticky, step_valid_reg, step_valid_reg, "computed step dropped")
    `ATC_ASSERT_NEXT(a_clamp_range, state_reg == ST_CLAMP && min_reg <= max_reg, cur_reg >= min_reg && cur_reg <= max_reg, "clamped step outside limits")

endmodule
